// ----- sv/fwck_pkg.sv -----
// Package for the four-wheel chassis kinematics block: types, constants and helpers.
package fwck_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 31;
    localparam int IDX_W     = 3;
    localparam int LANES     = 4;

    // Widths of the kinematic datapath, mostly derived from the data, gain and fraction widths.
    localparam int PROD_W  = DATA_W + GAIN_W + 1;
    localparam int W_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W   = W_W + 2;
    localparam int HI_W    = 25;
    localparam int LO_W    = SUM_W - HI_W;
    localparam int HPROD_W = HI_W + GAIN_W + 1;
    localparam int LPROD_W = LO_W + GAIN_W;
    localparam int MPROD_W = SUM_W + GAIN_W + 1;

    // Pipeline lengths of the two back-end units. The kinematic unit has three
    // registers ahead of its alignment pad, which brings it to the limit unit's length.
    localparam int KIN_LAT = 3;
    localparam int LIM_LAT = GAIN_W + 4;
    localparam int KIN_PAD = LIM_LAT - KIN_LAT;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_BITS);
    localparam logic [GAIN_W-1:0] LAT_RESET = GAIN_W'(1 << FRAC_BITS);

    localparam logic signed [MPROD_W-1:0] SAT_MAX = MPROD_W'(64'sd2147483647);
    localparam logic signed [MPROD_W-1:0] SAT_MIN = -SAT_MAX - MPROD_W'(64'sd1);

    typedef enum logic [1:0] {
        OP_INVERSE   = 2'd0,
        OP_FWD_VEL   = 2'd1,
        OP_FWD_DELTA = 2'd2,
        OP_LIMIT     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISABLED = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    typedef enum logic [IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_MODE     = 3'd1,
        REG_V2RPM    = 3'd2,
        REG_RPM2V    = 3'd3,
        REG_RADIUS   = 3'd4,
        REG_INV4R    = 3'd5,
        REG_LATERAL  = 3'd6,
        REG_MAXRPM   = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        CL_KIN   = 2'd0,
        CL_LIMIT = 2'd1,
        CL_OFF   = 2'd2
    } t_class;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value_0;
        logic signed [DATA_W-1:0] value_1;
        logic signed [DATA_W-1:0] value_2;
        logic signed [DATA_W-1:0] value_3;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_0;
        logic signed [DATA_W-1:0] result_1;
        logic signed [DATA_W-1:0] result_2;
        logic signed [DATA_W-1:0] result_3;
        t_status                  status;
    } t_result;

    typedef struct packed {
        logic              enable;
        logic              mode;
        logic [GAIN_W-1:0] velocity_to_rpm;
        logic [GAIN_W-1:0] rpm_to_velocity;
        logic [GAIN_W-1:0] rotation_radius;
        logic [GAIN_W-1:0] inverse_four_radius;
        logic [GAIN_W-1:0] lateral_scale;
        logic [GAIN_W-1:0] max_abs_rpm;
    } t_cfg;

    // Register values after reset: all zero except the lateral scale, which is one.
    localparam t_cfg CFG_RESET = {2'b00, {(4*GAIN_W){1'b0}}, LAT_RESET, {GAIN_W{1'b0}}};

    typedef struct packed {
        t_cmd   cmd;
        t_class cls;
    } t_job;

    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] val;
        logic                         sat;
    } t_lanes;

    // Clamp a wide signed value to 32 bits; the top bit flags saturation.
    function automatic logic [DATA_W:0] clamp32(input logic signed [MPROD_W-1:0] x);
        logic [DATA_W:0] r;
        if (x > SAT_MAX) begin
            r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end else if (x < SAT_MIN) begin
            r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, x[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

// ----- sv/fwck_front.sv -----
// Front end: configuration bank, command capture and classification.
module fwck_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  fwck_pkg::t_cmd           i_cmd,
    input  logic                     i_cfg_we,
    input  logic [fwck_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [fwck_pkg::GAIN_W-1:0] i_cfg_data,
    input  logic                     i_full,
    output logic                     o_busy,
    output logic                     o_push,
    output fwck_pkg::t_job           o_job,
    output fwck_pkg::t_cfg           o_cfg
);

    logic           r_valid;
    logic           n_valid;
    fwck_pkg::t_job r_job;
    fwck_pkg::t_job n_job;
    fwck_pkg::t_cfg r_cfg;
    logic           accept;

    assign o_busy = r_valid & i_full;
    assign o_push = r_valid & ~i_full;
    assign accept = i_start & ~o_busy;

    always_comb begin
        n_valid = accept | (r_valid & i_full);
        n_job   = r_job;
        if (accept) begin
            n_job.cmd = i_cmd;
            if (i_cmd.op == fwck_pkg::OP_LIMIT) begin
                n_job.cls = fwck_pkg::CL_LIMIT;
            end else if (!r_cfg.enable) begin
                n_job.cls = fwck_pkg::CL_OFF;
            end else begin
                n_job.cls = fwck_pkg::CL_KIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= fwck_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (fwck_pkg::t_reg'(i_cfg_idx))
                fwck_pkg::REG_ENABLE:  r_cfg.enable              <= i_cfg_data[0];
                fwck_pkg::REG_MODE:    r_cfg.mode                <= i_cfg_data[0];
                fwck_pkg::REG_V2RPM:   r_cfg.velocity_to_rpm     <= i_cfg_data;
                fwck_pkg::REG_RPM2V:   r_cfg.rpm_to_velocity     <= i_cfg_data;
                fwck_pkg::REG_RADIUS:  r_cfg.rotation_radius     <= i_cfg_data;
                fwck_pkg::REG_INV4R:   r_cfg.inverse_four_radius <= i_cfg_data;
                fwck_pkg::REG_LATERAL: r_cfg.lateral_scale       <= i_cfg_data;
                fwck_pkg::REG_MAXRPM:  r_cfg.max_abs_rpm         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_job = r_job;
    assign o_cfg = r_cfg;

endmodule

// ----- sv/fwck_queue.sv -----
// Two-entry queue of classified jobs between the front and back ends.
module fwck_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fwck_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output fwck_pkg::t_job o_job
);

    fwck_pkg::t_job r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic           pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign pop     = i_pop & o_valid;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

endmodule

// ----- sv/fwck_kin.sv -----
// Kinematic unit: inverse and forward chassis transforms, four-stage pipeline plus alignment.
module fwck_kin (
    input  logic             i_clk,
    input  fwck_pkg::t_cmd   i_cmd,
    input  fwck_pkg::t_cfg   i_cfg,
    output fwck_pkg::t_lanes o_lanes
);

    localparam int D  = fwck_pkg::DATA_W;
    localparam int G  = fwck_pkg::GAIN_W;
    localparam int PW = fwck_pkg::PROD_W;
    localparam int WW = fwck_pkg::W_W;
    localparam int SW = fwck_pkg::SUM_W;
    localparam int LW = fwck_pkg::LO_W;
    localparam int F  = fwck_pkg::FRAC_BITS;

    logic signed [D-1:0]                       v_in [4];
    logic signed [PW-1:0]                      n_p1 [4];
    logic signed [PW-1:0]                      r_p1 [4];
    logic signed [D-1:0]                       r_v1 [4];
    fwck_pkg::t_op                             r_op1;

    logic signed [SW-1:0]                      n_opd [4];
    logic [G-1:0]                              n_g   [4];
    logic signed [SW-1:0]                      r_opd [4];
    logic [G-1:0]                              r_g   [4];

    logic signed [fwck_pkg::HPROD_W-1:0]       n_hi [4];
    logic [fwck_pkg::LPROD_W-1:0]              n_lo [4];
    logic signed [fwck_pkg::HPROD_W-1:0]       r_hi [4];
    logic [fwck_pkg::LPROD_W-1:0]              r_lo [4];

    fwck_pkg::t_lanes                          n_res;
    fwck_pkg::t_lanes                          r_pad [fwck_pkg::KIN_PAD];

    assign v_in[0] = i_cmd.value_0;
    assign v_in[1] = i_cmd.value_1;
    assign v_in[2] = i_cmd.value_2;
    assign v_in[3] = i_cmd.value_3;

    // Stage 1: rotation term or rpm-to-velocity products.
    always_comb begin
        logic [G-1:0] gain;
        gain = (i_cmd.op == fwck_pkg::OP_INVERSE) ? i_cfg.rotation_radius
                                                  : i_cfg.rpm_to_velocity;
        for (int i = 0; i < 4; i++) begin
            n_p1[i] = v_in[i] * $signed({1'b0, gain});
        end
    end

    // Stage 2: wheel mixing sums and the gain each lane is scaled by.
    always_comb begin
        logic signed [WW-1:0] w [4];
        logic signed [SW-1:0] vx, vy, rot, sx, sy, sz;
        for (int i = 0; i < 4; i++) begin
            if (r_op1 == fwck_pkg::OP_FWD_DELTA) begin
                w[i] = WW'(r_v1[i]);
            end else begin
                w[i] = $signed(r_p1[i][PW-1:F]);
            end
        end
        vx  = SW'(r_v1[0]);
        vy  = SW'(r_v1[1]);
        rot = SW'(w[2]);
        if (!i_cfg.mode) begin
            sx = SW'(w[0]) - SW'(w[1]) - SW'(w[2]) + SW'(w[3]);
            sy = SW'(w[0]) + SW'(w[1]) - SW'(w[2]) - SW'(w[3]);
            sz = -(SW'(w[0]) + SW'(w[1]) + SW'(w[2]) + SW'(w[3]));
        end else begin
            sx = SW'(w[0]) + SW'(w[1]) + SW'(w[2]) + SW'(w[3]);
            sy = -SW'(w[0]) + SW'(w[1]) - SW'(w[2]) + SW'(w[3]);
            sz = -SW'(w[0]) - SW'(w[1]) + SW'(w[2]) + SW'(w[3]);
        end
        if (r_op1 == fwck_pkg::OP_INVERSE) begin
            if (!i_cfg.mode) begin
                n_opd[0] = vx + vy - rot;
                n_opd[1] = -vx + vy - rot;
                n_opd[2] = -vx - vy - rot;
                n_opd[3] = vx - vy - rot;
            end else begin
                n_opd[0] = vx - vy - rot;
                n_opd[1] = vx + vy - rot;
                n_opd[2] = vx - vy + rot;
                n_opd[3] = vx + vy + rot;
            end
            for (int i = 0; i < 4; i++) begin
                n_g[i] = i_cfg.velocity_to_rpm;
            end
        end else begin
            // A unit gain passes a lane through the clamp unchanged.
            n_opd[0] = sx >>> 2;
            n_opd[1] = sy >>> 2;
            n_opd[2] = sz;
            n_opd[3] = '0;
            n_g[0]   = fwck_pkg::GAIN_ONE;
            n_g[1]   = i_cfg.mode ? i_cfg.lateral_scale : fwck_pkg::GAIN_ONE;
            n_g[2]   = i_cfg.inverse_four_radius;
            n_g[3]   = fwck_pkg::GAIN_ONE;
        end
    end

    // Stage 3: the wide gain product split into two partial products.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_hi[i] = $signed(r_opd[i][SW-1:LW]) * $signed({1'b0, r_g[i]});
            n_lo[i] = r_opd[i][LW-1:0] * r_g[i];
        end
    end

    // Stage 4: recombine, drop the fraction (floor) and clamp.
    always_comb begin
        logic signed [fwck_pkg::MPROD_W-1:0] full;
        logic [D:0]                          c;
        n_res.sat = 1'b0;
        for (int i = 0; i < 4; i++) begin
            full = (fwck_pkg::MPROD_W'(r_hi[i]) <<< LW)
                 + $signed({{(fwck_pkg::MPROD_W-fwck_pkg::LPROD_W){1'b0}}, r_lo[i]});
            c = fwck_pkg::clamp32(full >>> F);
            n_res.val[i] = c[D-1:0];
            n_res.sat    = n_res.sat | c[D];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_p1[i]  <= n_p1[i];
            r_v1[i]  <= v_in[i];
            r_opd[i] <= n_opd[i];
            r_g[i]   <= n_g[i];
            r_hi[i]  <= n_hi[i];
            r_lo[i]  <= n_lo[i];
        end
        r_op1    <= i_cmd.op;
        r_pad[0] <= n_res;
        for (int k = 1; k < fwck_pkg::KIN_PAD; k++) begin
            r_pad[k] <= r_pad[k-1];
        end
    end

    assign o_lanes = r_pad[fwck_pkg::KIN_PAD-1];

endmodule

// ----- sv/fwck_limit.sv -----
// Limit unit: proportional wheel scaling with a pipelined restoring divider, one bit per stage.
module fwck_limit (
    input  logic                        i_clk,
    input  fwck_pkg::t_cmd              i_cmd,
    input  logic [fwck_pkg::GAIN_W-1:0] i_max,
    output fwck_pkg::t_lanes            o_lanes
);

    localparam int D = fwck_pkg::DATA_W;
    localparam int G = fwck_pkg::GAIN_W;

    logic signed [D-1:0] v_in [4];

    logic [D-1:0]        r_a1 [4];
    logic [D-1:0]        r_v1 [4];
    logic [D-1:0]        r_a2 [4];
    logic [D-1:0]        r_v2 [4];
    logic [D-1:0]        r_mx2;
    logic                r_le2;
    logic [D+G-1:0]      r_pr3 [4];
    logic [D-1:0]        r_v3 [4];
    logic [D-1:0]        r_mx3;
    logic                r_le3;

    logic [D-1:0]        r_rem [G][4];
    logic [G-1:0]        r_low [G][4];
    logic [G-1:0]        r_q   [G][4];
    logic [D-1:0]        r_dv  [G][4];
    logic [D-1:0]        r_dmx [G];
    logic                r_dle [G];

    logic [D-1:0]        n_rem [G][4];
    logic [G-1:0]        n_low [G][4];
    logic [G-1:0]        n_q   [G][4];
    logic [D-1:0]        n_mx2;
    fwck_pkg::t_lanes    n_res;
    fwck_pkg::t_lanes    r_res;

    assign v_in[0] = i_cmd.value_0;
    assign v_in[1] = i_cmd.value_1;
    assign v_in[2] = i_cmd.value_2;
    assign v_in[3] = i_cmd.value_3;

    always_comb begin
        logic [D-1:0] m01, m23;
        m01   = (r_a1[0] > r_a1[1]) ? r_a1[0] : r_a1[1];
        m23   = (r_a1[2] > r_a1[3]) ? r_a1[2] : r_a1[3];
        n_mx2 = (m01 > m23) ? m01 : m23;
    end

    // One quotient bit per stage; the dividend's low bits shift in from the top.
    always_comb begin
        logic [D-1:0] rem_in;
        logic [G-1:0] low_in;
        logic [G-1:0] q_in;
        logic [D-1:0] mx;
        logic [D:0]   t;
        for (int j = 0; j < G; j++) begin
            for (int i = 0; i < 4; i++) begin
                if (j == 0) begin
                    rem_in = r_pr3[i][D+G-1:G];
                    low_in = r_pr3[i][G-1:0];
                    q_in   = '0;
                    mx     = r_mx3;
                end else begin
                    rem_in = r_rem[j-1][i];
                    low_in = r_low[j-1][i];
                    q_in   = r_q[j-1][i];
                    mx     = r_dmx[j-1];
                end
                t = {rem_in, low_in[G-1]};
                n_low[j][i] = {low_in[G-2:0], 1'b0};
                if (t >= {1'b0, mx}) begin
                    n_rem[j][i] = D'(t - {1'b0, mx});
                    n_q[j][i]   = {q_in[G-2:0], 1'b1};
                end else begin
                    n_rem[j][i] = t[D-1:0];
                    n_q[j][i]   = {q_in[G-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic [D-1:0] q;
        n_res.sat = 1'b0;
        for (int i = 0; i < 4; i++) begin
            q = D'(r_q[G-1][i]);
            if (r_dle[G-1]) begin
                n_res.val[i] = r_dv[G-1][i];
            end else if (r_dv[G-1][i][D-1]) begin
                n_res.val[i] = -q;
            end else begin
                n_res.val[i] = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_a1[i]  <= v_in[i][D-1] ? D'(-v_in[i]) : D'(v_in[i]);
            r_v1[i]  <= v_in[i];
            r_a2[i]  <= r_a1[i];
            r_v2[i]  <= r_v1[i];
            r_pr3[i] <= r_a2[i] * i_max;
            r_v3[i]  <= r_v2[i];
        end
        r_mx2 <= n_mx2;
        r_le2 <= (n_mx2 <= {1'b0, i_max});
        r_mx3 <= r_mx2;
        r_le3 <= r_le2;
        for (int j = 0; j < G; j++) begin
            for (int i = 0; i < 4; i++) begin
                r_rem[j][i] <= n_rem[j][i];
                r_low[j][i] <= n_low[j][i];
                r_q[j][i]   <= n_q[j][i];
                r_dv[j][i]  <= (j == 0) ? r_v3[i] : r_dv[j-1][i];
            end
            r_dmx[j] <= (j == 0) ? r_mx3 : r_dmx[j-1];
            r_dle[j] <= (j == 0) ? r_le3 : r_dle[j-1];
        end
        r_res <= n_res;
    end

    assign o_lanes = r_res;

endmodule

// ----- sv/four_wheel_chassis_kinematics_top.sv -----
// Each accepted command gets a result strobe after the front, queue, unit and output registers.
// Throughput: one command per cycle while busy is low; the 31-stage divider of the limit unit sets the latency.
// Results cannot be held off, so the back end never stalls and busy stays low in practice.
// Reset (synchronous, active low) empties the pipeline and loads the register reset values.
// Top level of the four-wheel chassis kinematics block.
module four_wheel_chassis_kinematics_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  fwck_pkg::t_cmd              i_cmd,
    input  logic                        i_cfg_we,
    input  logic [fwck_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [fwck_pkg::GAIN_W-1:0] i_cfg_data,
    output logic                        o_strobe,
    output fwck_pkg::t_result           o_result
);

    // The front end captures each command beat, tags it as kinematic, limit or
    // disabled, and pushes it into a two-entry queue. The back end pops the queue
    // every cycle and feeds both units; a sideband line carries the tag so the
    // right unit's answer is picked when both reach the end together.

    fwck_pkg::t_cfg   cfg;
    fwck_pkg::t_job   front_job;
    fwck_pkg::t_job   head_job;
    fwck_pkg::t_lanes kin_lanes;
    fwck_pkg::t_lanes lim_lanes;
    logic             push;
    logic             full;
    logic             head_valid;

    logic             r_sv  [fwck_pkg::LIM_LAT];
    fwck_pkg::t_class r_scl [fwck_pkg::LIM_LAT];
    logic             r_strobe;
    fwck_pkg::t_result r_result;
    fwck_pkg::t_result n_result;

    fwck_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_busy     (busy),
        .o_push     (push),
        .o_job      (front_job),
        .o_cfg      (cfg)
    );

    fwck_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (head_valid),
        .o_valid (head_valid),
        .o_full  (full),
        .o_job   (head_job)
    );

    fwck_kin u_kin (
        .i_clk   (i_clk),
        .i_cmd   (head_job.cmd),
        .i_cfg   (cfg),
        .o_lanes (kin_lanes)
    );

    fwck_limit u_limit (
        .i_clk   (i_clk),
        .i_cmd   (head_job.cmd),
        .i_max   (cfg.max_abs_rpm),
        .o_lanes (lim_lanes)
    );

    // Pick the answer for the job that reaches the end of the units this cycle.
    always_comb begin
        fwck_pkg::t_class cls;
        cls = r_scl[fwck_pkg::LIM_LAT-1];
        n_result = '0;
        case (cls)
            fwck_pkg::CL_KIN: begin
                n_result.result_0 = kin_lanes.val[0];
                n_result.result_1 = kin_lanes.val[1];
                n_result.result_2 = kin_lanes.val[2];
                n_result.result_3 = kin_lanes.val[3];
                n_result.status   = kin_lanes.sat ? fwck_pkg::ST_SAT : fwck_pkg::ST_OK;
            end
            fwck_pkg::CL_LIMIT: begin
                n_result.result_0 = lim_lanes.val[0];
                n_result.result_1 = lim_lanes.val[1];
                n_result.result_2 = lim_lanes.val[2];
                n_result.result_3 = lim_lanes.val[3];
                n_result.status   = fwck_pkg::ST_OK;
            end
            fwck_pkg::CL_OFF: begin
                n_result.status = fwck_pkg::ST_DISABLED;
            end
            default: begin
                n_result.status = fwck_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_scl[0] <= head_job.cls;
        for (int k = 1; k < fwck_pkg::LIM_LAT; k++) begin
            r_scl[k] <= r_scl[k-1];
        end
        r_result <= n_result;
        if (!i_rst_n) begin
            for (int k = 0; k < fwck_pkg::LIM_LAT; k++) begin
                r_sv[k] <= 1'b0;
            end
            r_strobe <= 1'b0;
        end else begin
            r_sv[0] <= head_valid;
            for (int k = 1; k < fwck_pkg::LIM_LAT; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_strobe <= r_sv[fwck_pkg::LIM_LAT-1];
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // The back end drains the queue every cycle, so the front never sees it full.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("front end stalled on a full queue");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(push && full))
        else $error("job pushed into a full queue");

    a_disabled_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == fwck_pkg::ST_DISABLED) |->
        (o_result.result_0 == '0 && o_result.result_1 == '0 &&
         o_result.result_2 == '0 && o_result.result_3 == '0))
        else $error("disabled result beat carries nonzero values");

endmodule
